/* rtl/text_tokenizer_with_lines_macros.svh */
// Assertion macros used by the checker file.
`ifndef TEXT_TOKENIZER_WITH_LINES_MACROS_SVH
`define TEXT_TOKENIZER_WITH_LINES_MACROS_SVH

// Same-cycle implication, held off during reset.
`define TXTOK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define TXTOK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/txtok_pkg.sv */
`timescale 1ns / 1ps

package txtok_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 32;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_DOUBLE = 2'd1;
  localparam logic [1:0] Q_SINGLE = 2'd2;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0]  token_byte;
    logic [15:0] token_number;
    logic [15:0] line_number;
    logic        last_byte;
    logic        truncated;
  } out_t;

  // ( ) ; , : # { }
  function automatic logic is_mark(input logic [7:0] b);
    return b inside {8'h28, 8'h29, 8'h3B, 8'h2C, 8'h3A, 8'h23, 8'h7B, 8'h7D};
  endfunction

  // space, tab, newline, vertical tab, form feed, carriage return, NUL
  function automatic logic is_sep(input logic [7:0] b);
    return b inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h00};
  endfunction

endpackage

/* rtl/text_tokenizer_with_lines.sv */
`timescale 1ns / 1ps
// A closing byte starts a replay of the n buffered bytes: S_READ reads the first byte, then
// S_EMIT registers one byte a cycle while the output is not stalled.
// A mark token is registered in S_MARK, entered on its accepting edge or after a word's replay.
// Input stalls whenever the block is out of S_IDLE: during the read, the replay and a mark token.
// Reset (rst_n low, synchronous) resets counters, quote state and output valid; buffer unchanged.
module text_tokenizer_with_lines #(
  parameter int MAX_TOKEN_LEN = txtok_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  txtok_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output txtok_pkg::out_t  out_data
);

  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int AW = $clog2(MAX_TOKEN_LEN);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_TOKEN_LEN);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_MARK = 2'd3;

  logic [7:0] mem [MAX_TOKEN_LEN];

  logic [1:0]      state_r, state_nxt;
  logic [LW-1:0]   length_r, length_nxt;
  logic [1:0]      quote_r, quote_nxt;
  logic [15:0]     line_r, line_nxt;
  logic [15:0]     tok_r, tok_nxt;
  logic            ovf_r, ovf_nxt;
  logic [AW-1:0]   rd_idx_r, rd_idx_nxt;
  logic            mark_pend_r, mark_pend_nxt;
  logic [7:0]      mark_byte_r, mark_byte_nxt;
  logic            eot_pend_r, eot_pend_nxt;
  logic [7:0]      rdata_r;
  logic            out_valid_r, out_valid_nxt;
  txtok_pkg::out_t out_data_r, out_data_nxt;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data;
  logic          out_free, is_last, do_store, go_flush;
  logic [7:0]    b;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign b         = in_data.text_byte;
  assign is_last   = (LW'(rd_idx_r) + LW'(1)) == length_r;

  always_comb begin
    state_nxt     = state_r;
    length_nxt    = length_r;
    quote_nxt     = quote_r;
    line_nxt      = line_r;
    tok_nxt       = tok_r;
    ovf_nxt       = ovf_r;
    rd_idx_nxt    = rd_idx_r;
    mark_pend_nxt = mark_pend_r;
    mark_byte_nxt = mark_byte_r;
    eot_pend_nxt  = eot_pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = length_r[AW-1:0];
    wr_data       = b;
    rd_en         = 1'b0;
    rd_addr       = rd_idx_r;
    do_store      = 1'b0;
    go_flush      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.end_of_text) begin
            if (quote_r == txtok_pkg::Q_NONE && length_r != '0) begin
              eot_pend_nxt = 1'b1;
              go_flush     = 1'b1;
            end else begin
              length_nxt = '0;
              quote_nxt  = txtok_pkg::Q_NONE;
              line_nxt   = 16'd1;
              tok_nxt    = '0;
              ovf_nxt    = 1'b0;
            end
          end else begin
            if (b == txtok_pkg::CH_NL && line_r != txtok_pkg::COUNT_MAX) begin
              line_nxt = line_r + 16'd1;
            end
            if (quote_r != txtok_pkg::Q_NONE) begin
              do_store = 1'b1;
              if ((quote_r == txtok_pkg::Q_DOUBLE && b == txtok_pkg::CH_DQUOTE) ||
                  (quote_r == txtok_pkg::Q_SINGLE && b == txtok_pkg::CH_SQUOTE)) begin
                quote_nxt = txtok_pkg::Q_NONE;
                go_flush  = 1'b1;
              end
            end else if (b == txtok_pkg::CH_DQUOTE) begin
              quote_nxt = txtok_pkg::Q_DOUBLE;
              do_store  = 1'b1;
            end else if (b == txtok_pkg::CH_SQUOTE) begin
              quote_nxt = txtok_pkg::Q_SINGLE;
              do_store  = 1'b1;
            end else if (txtok_pkg::is_sep(b) || txtok_pkg::is_mark(b)) begin
              mark_pend_nxt = txtok_pkg::is_mark(b);
              mark_byte_nxt = b;
              if (length_r != '0) begin
                go_flush = 1'b1;
              end else if (txtok_pkg::is_mark(b)) begin
                state_nxt = S_MARK;
              end
            end else begin
              do_store = 1'b1;
            end
          end
          if (do_store) begin
            if (length_r < LEN_MAX) begin
              wr_en      = 1'b1;
              length_nxt = length_r + LW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (go_flush) begin
            rd_idx_nxt = '0;
            state_nxt  = S_READ;
          end
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.token_byte   = rdata_r;
          out_data_nxt.token_number = tok_r;
          out_data_nxt.line_number  = line_r;
          out_data_nxt.last_byte    = is_last;
          out_data_nxt.truncated    = ovf_r;
          if (is_last) begin
            if (tok_r != txtok_pkg::COUNT_MAX) begin
              tok_nxt = tok_r + 16'd1;
            end
            length_nxt = '0;
            ovf_nxt    = 1'b0;
            if (eot_pend_r) begin
              eot_pend_nxt = 1'b0;
              quote_nxt    = txtok_pkg::Q_NONE;
              line_nxt     = 16'd1;
              tok_nxt      = '0;
              state_nxt    = S_IDLE;
            end else if (mark_pend_r) begin
              state_nxt = S_MARK;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            rd_idx_nxt = rd_idx_r + AW'(1);
            rd_addr    = rd_idx_r + AW'(1);
            rd_en      = 1'b1;
          end
        end
      end
      S_MARK: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.token_byte   = mark_byte_r;
          out_data_nxt.token_number = tok_r;
          out_data_nxt.line_number  = line_r;
          out_data_nxt.last_byte    = 1'b1;
          out_data_nxt.truncated    = 1'b0;
          if (tok_r != txtok_pkg::COUNT_MAX) begin
            tok_nxt = tok_r + 16'd1;
          end
          mark_pend_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // word buffer, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      length_r    <= '0;
      quote_r     <= txtok_pkg::Q_NONE;
      line_r      <= 16'd1;
      tok_r       <= '0;
      ovf_r       <= 1'b0;
      rd_idx_r    <= '0;
      mark_pend_r <= 1'b0;
      eot_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      length_r    <= length_nxt;
      quote_r     <= quote_nxt;
      line_r      <= line_nxt;
      tok_r       <= tok_nxt;
      ovf_r       <= ovf_nxt;
      rd_idx_r    <= rd_idx_nxt;
      mark_pend_r <= mark_pend_nxt;
      eot_pend_r  <= eot_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mark_byte_r <= mark_byte_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

/* rtl/txtok_checker.sv */
`timescale 1ns / 1ps
`include "text_tokenizer_with_lines_macros.svh"

module txtok_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input txtok_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_stall,
  input txtok_pkg::out_t out_data
);

  // held input beat keeps its payload
  `TXTOK_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_data), "in beat changed while stalled")

  // held result beat keeps its payload
  `TXTOK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "out beat changed while stalled")

  `TXTOK_ASSERT_NOW(a_line_nonzero, clk, rst_n, out_valid, out_data.line_number != 16'd0, "line number zero")

  // mid-token beat means replay is running, so input is held off
  `TXTOK_ASSERT_NOW(a_mid_token_busy, clk, rst_n, out_valid && !out_data.last_byte, in_stall, "input open during token replay")

endmodule

bind text_tokenizer_with_lines txtok_checker u_txtok_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int RANDOM_ITEMS = 240;

  class token_predictor;
    logic [7:0]  held_word [txtok_pkg::MAX_TOKEN_LEN_DEF];
    int unsigned held_len;
    logic [1:0]  quote_kind;
    logic [15:0] line_no;
    logic [15:0] tok_no;
    bit          dropped;
    txtok_pkg::out_t pending_bytes [$];
    int          fails;

    function new();
      clear();
      fails = 0;
    endfunction

    function void clear();
      held_len   = 0;
      quote_kind = txtok_pkg::Q_NONE;
      line_no    = 16'd1;
      tok_no     = 16'd0;
      dropped    = 1'b0;
    endfunction

    function bit punct_byte(logic [7:0] b);
      case (b)
        "(", ")", ";", ",", ":", "#", "{", "}": return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit blank_byte(logic [7:0] b);
      case (b)
        8'h20, 8'h09, txtok_pkg::CH_NL, 8'h0B, 8'h0C, 8'h0D, 8'h00: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void push_byte(logic [7:0] b, bit last, bit trunc);
      txtok_pkg::out_t r;
      r.token_byte   = b;
      r.token_number = tok_no;
      r.line_number  = line_no;
      r.last_byte    = last;
      r.truncated    = trunc;
      pending_bytes.push_back(r);
    endfunction

    function void bump_token();
      if (tok_no != txtok_pkg::COUNT_MAX) tok_no++;
    endfunction

    function void emit_word();
      if (held_len == 0) return;
      for (int i = 0; i < held_len; i++) push_byte(held_word[i], i + 1 == held_len, dropped);
      bump_token();
      held_len = 0;
      dropped  = 1'b0;
    endfunction

    function void keep_byte(logic [7:0] b);
      if (held_len < txtok_pkg::MAX_TOKEN_LEN_DEF) begin
        held_word[held_len] = b;
        held_len++;
      end else begin
        dropped = 1'b1;
      end
    endfunction

    function void note_input(txtok_pkg::in_t v);
      logic [7:0] b;
      b = v.text_byte;
      if (v.end_of_text) begin
        if (quote_kind == txtok_pkg::Q_NONE) emit_word();
        clear();
        return;
      end
      if (b == txtok_pkg::CH_NL && line_no != txtok_pkg::COUNT_MAX) line_no++;
      if (quote_kind != txtok_pkg::Q_NONE) begin
        keep_byte(b);
        if ((quote_kind == txtok_pkg::Q_DOUBLE && b == txtok_pkg::CH_DQUOTE) ||
            (quote_kind == txtok_pkg::Q_SINGLE && b == txtok_pkg::CH_SQUOTE)) begin
          emit_word();
          quote_kind = txtok_pkg::Q_NONE;
        end
        return;
      end
      if (b == txtok_pkg::CH_DQUOTE || b == txtok_pkg::CH_SQUOTE) begin
        quote_kind = (b == txtok_pkg::CH_DQUOTE) ? txtok_pkg::Q_DOUBLE : txtok_pkg::Q_SINGLE;
        keep_byte(b);
        return;
      end
      if (blank_byte(b) || punct_byte(b)) begin
        emit_word();
        if (punct_byte(b)) begin
          push_byte(b, 1'b1, 1'b0);
          bump_token();
        end
        return;
      end
      keep_byte(b);
    endfunction

    task report(string msg);
      fails++;
      $display("tb: error: %s", msg);
    endtask

    task check_result(txtok_pkg::out_t got);
      txtok_pkg::out_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected beat, byte %h", got.token_byte));
        return;
      end
      want = pending_bytes.pop_front();
      if (got.token_byte !== want.token_byte)
        report($sformatf("token_byte %h, want %h", got.token_byte, want.token_byte));
      if (got.token_number !== want.token_number)
        report($sformatf("token_number %0d, want %0d", got.token_number, want.token_number));
      if (got.line_number !== want.line_number)
        report($sformatf("line_number %0d, want %0d", got.line_number, want.line_number));
      if (got.last_byte !== want.last_byte)
        report($sformatf("last_byte %b, want %b", got.last_byte, want.last_byte));
      if (got.truncated !== want.truncated)
        report($sformatf("truncated %b, want %b", got.truncated, want.truncated));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  txtok_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  txtok_pkg::out_t out_data;

  token_predictor sb = new();
  bit quiet = 1'b0;
  int stall_left = 0;
  int sent = 0;
  int cycles = 0;

  text_tokenizer_with_lines dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("tb: FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (quiet || stall_left == 0) begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end else begin
      out_stall <= 1'b1;
      stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) sb.check_result(out_data);
  end

  // entered and left just after a falling edge
  task automatic send_beat(input txtok_pkg::in_t v);
    int idle;
    idle = quiet ? 0 : pick_gap();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(v);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    txtok_pkg::in_t v;
    v.text_byte   = b;
    v.end_of_text = 1'b0;
    send_beat(v);
  endtask

  task automatic send_end();
    txtok_pkg::in_t v;
    v.text_byte   = 8'($urandom_range(0, 255));
    v.end_of_text = 1'b1;
    send_beat(v);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] mark_pick();
    case ($urandom_range(0, 7))
      0: return "(";
      1: return ")";
      2: return ";";
      3: return ",";
      4: return ":";
      5: return "#";
      6: return "{";
      default: return "}";
    endcase
  endfunction

  function automatic logic [7:0] blank_pick();
    case ($urandom_range(0, 6))
      0: return 8'h20;
      1: return 8'h09;
      2: return txtok_pkg::CH_NL;
      3: return 8'h0B;
      4: return 8'h0C;
      5: return 8'h0D;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 3) != 0) b = 8'($urandom_range(8'h61, 8'h7A));
      else b = 8'($urandom_range(0, 255));
    end while (sb.blank_byte(b) || sb.punct_byte(b) || b == txtok_pkg::CH_DQUOTE ||
               b == txtok_pkg::CH_SQUOTE);
    return b;
  endfunction

  // mostly short, now and then past the end of the buffer
  function automatic int piece_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 31);
    return $urandom_range(32, 40);
  endfunction

  task automatic word_piece(input int n);
    repeat (n) send_byte(word_char());
  endtask

  task automatic string_piece();
    logic [7:0] q;
    logic [7:0] b;
    int n;
    q = $urandom_range(0, 1) ? txtok_pkg::CH_DQUOTE : txtok_pkg::CH_SQUOTE;
    n = piece_len();
    send_byte(q);
    repeat (n) begin
      do begin
        if ($urandom_range(0, 9) == 0) b = txtok_pkg::CH_NL;
        else b = 8'($urandom_range(0, 255));
      end while (b == q);
      send_byte(b);
    end
    if ($urandom_range(0, 9) == 0) send_end();
    else send_byte(q);
  endtask

  initial begin
    int r;
    int start;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_text("q(\t)");
    send_byte(8'h0B);
    send_text(";");
    send_byte(8'h0C);
    send_text(",");
    send_byte(8'h0D);
    send_text(":# {}");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_text("\"a'\nb\"");
    send_text("z'k'");
    send_text("m");
    send_end();
    send_text("\"u");
    send_end();

    start = sent;
    while (sent < start + RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) quiet = !quiet;
      r = $urandom_range(0, 99);
      if (r < 35) begin
        word_piece(piece_len());
        if ($urandom_range(0, 1)) send_byte(blank_pick());
        else send_byte(mark_pick());
      end else if (r < 50) begin
        send_byte(mark_pick());
      end else if (r < 62) begin
        send_byte(blank_pick());
      end else if (r < 80) begin
        if ($urandom_range(0, 3) == 0) word_piece($urandom_range(1, 4));
        string_piece();
      end else if (r < 86) begin
        send_end();
      end else if (r < 94) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(txtok_pkg::CH_NL);
      end
    end
    send_end();
    in_valid <= 1'b0;

    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.fails == 0 && sb.pending_bytes.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
